// ===== src/gni_pkg.sv =====
// Shared types, constants and helpers for the grid Newton interpolator.
`default_nettype none
package gni_pkg;
    localparam int MaxNodesX = 16;
    localparam int MaxNodesY = 16;
    localparam int MaxPoints = 8;
    localparam int XIdxW = $clog2(MaxNodesX);
    localparam int YIdxW = $clog2(MaxNodesY);
    localparam int PtIdxW = $clog2(MaxPoints);
    localparam int GridAw = XIdxW + YIdxW;

    typedef enum logic [1:0] {
        OP_LOAD_X = 2'd0,
        OP_LOAD_Y = 2'd1,
        OP_LOAD_Z = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_X_USED = 2'd0,
        REG_Y_USED = 2'd1,
        REG_PTS_X  = 2'd2,
        REG_PTS_Y  = 2'd3
    } t_reg_idx;

    localparam logic [1:0] StOk   = 2'd0;
    localparam logic [1:0] StSat  = 2'd1;
    localparam logic [1:0] StZero = 2'd2;

    typedef struct packed {
        logic               req;
        logic signed [63:0] num;
        logic signed [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] quo;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic is_sat(input logic signed [65:0] v);
        return (v > 66'sd2147483647) || (v < -66'sd2147483648);
    endfunction
endpackage
`default_nettype wire

// ===== src/gni_if.sv =====
// Valid/ready channel interfaces for items, results and configuration writes.
`default_nettype none
interface gni_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [3:0]  row_index;
    logic [3:0]  col_index;
    logic signed [31:0] load_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    modport source (output valid, opcode, row_index, col_index, load_value, query_x,
                    query_y, input ready);
    modport sink (input valid, opcode, row_index, col_index, load_value, query_x,
                  query_y, output ready);
endinterface

interface gni_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result_value;
    logic [1:0]  status;
    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface

interface gni_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/gni_div.sv =====
// Radix-2 restoring signed divider, 64-bit, truncating toward zero.
`default_nettype none
module gni_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gni_pkg::t_div_req i_req,
    output gni_pkg::t_div_rsp      o_rsp
);
    import gni_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic        r_neg;
    logic [64:0] n_trial;
    logic [63:0] n_shift;

    assign n_shift = {r_rem[62:0], r_quo[63]};
    assign n_trial = {1'b0, n_shift} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.req) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_rem  <= '0;
                r_quo  <= i_req.num[63] ? 64'(-i_req.num) : i_req.num;
                r_den  <= i_req.den[63] ? 64'(-i_req.den) : i_req.den;
                r_neg  <= i_req.num[63] ^ i_req.den[63];
            end else if (r_busy) begin
                if (!n_trial[64]) begin
                    r_rem <= n_trial[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.quo  = r_neg ? 64'(-r_quo) : r_quo;
    end
endmodule
`default_nettype wire

// ===== src/gni_store.sv =====
// Node and grid memories with one registered read port each.
`default_nettype none
module gni_store (
    input  wire logic                       i_clk,
    input  wire logic                       i_wx,
    input  wire logic                       i_wy,
    input  wire logic                       i_wz,
    input  wire logic [gni_pkg::XIdxW-1:0]  i_wrow,
    input  wire logic [gni_pkg::YIdxW-1:0]  i_wcol,
    input  wire logic signed [31:0]         i_wdata,
    input  wire logic [gni_pkg::XIdxW-1:0]  i_rx,
    input  wire logic [gni_pkg::YIdxW-1:0]  i_ry,
    input  wire logic [gni_pkg::GridAw-1:0] i_rz,
    output logic signed [31:0]              o_x,
    output logic signed [31:0]              o_y,
    output logic signed [31:0]              o_z
);
    import gni_pkg::*;

    logic signed [31:0] r_xmem [MaxNodesX];
    logic signed [31:0] r_ymem [MaxNodesY];
    logic signed [31:0] r_zmem [MaxNodesX*MaxNodesY];

    always_ff @(posedge i_clk) begin
        if (i_wx) r_xmem[i_wrow] <= i_wdata;
        if (i_wy) r_ymem[i_wcol] <= i_wdata;
        if (i_wz) r_zmem[{i_wrow, i_wcol}] <= i_wdata;
        o_x <= r_xmem[i_rx];
        o_y <= r_ymem[i_ry];
        o_z <= r_zmem[i_rz];
    end
endmodule
`default_nettype wire

// ===== src/grid_newton_interpolator_2d_unit.sv =====
// Grid Newton interpolator: load sequencing, window search and Newton evaluation.
// Usage:
//   i_in carries transactions; opcode selects a load of an x node, a y node or a
//   grid value, or a query. Loads produce no result.
//   A query produces exactly one transaction on o_out: the interpolated value
//   in signed Q16.16 and a status (ok, saturated, repeated node).
//   i_cfg writes the node counts and point counts; write only while idle.
// Throughput:
//   One query at a time. Each divided difference passes through the divider (issue,
//   divider load, 64 serial steps, quotient take-up); the window search, the window
//   point reads and the Horner steps of each pass add to this. The divider dominates.
// Reset:
//   Registers return to 16 nodes and 4 points on each axis; the tables hold
//   nothing defined until loaded. No clearing pass is needed.
// Stall:
//   The result stays in the output register until taken. Loads and the next query
//   are still accepted; a query that finishes meanwhile holds until the register frees.
`default_nettype none
module grid_newton_interpolator_2d_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gni_in_if.sink    i_in,
    gni_cfg_if.sink   i_cfg,
    gni_out_if.source o_out
);
    import gni_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_X, S_SRCH_Y, S_ROW_LD, S_ROW_LD2, S_DIV_SET, S_DIV_WAIT,
        S_HORNER, S_HORN_MUL, S_NEXT, S_DONE
    } t_state;

    t_state              r_state;
    logic [4:0]          r_nx_used, r_ny_used;
    logic [3:0]          r_px_cfg, r_py_cfg;
    logic signed [31:0]  r_qx, r_qy;
    logic [4:0]          r_nx, r_ny;
    logic [3:0]          r_px, r_py;
    logic [4:0]          r_idx;
    logic                r_found;
    logic [XIdxW-1:0]    r_sx;
    logic [YIdxW-1:0]    r_sy;
    logic                r_xpass;
    logic [PtIdxW:0]     r_row;
    logic [PtIdxW:0]     r_ld;
    logic [PtIdxW:0]     r_lvl, r_j;
    logic                r_rdv;
    logic [PtIdxW:0]     r_rdj;
    logic signed [31:0]  r_win [MaxPoints];
    logic signed [31:0]  r_dw [MaxPoints];
    logic signed [31:0]  r_coef [MaxPoints];
    logic signed [31:0]  r_rowres [MaxPoints];
    logic signed [31:0]  r_p, r_d;
    logic signed [63:0]  r_prod;
    logic                r_sat, r_zero;
    logic                r_ovalid;
    logic signed [31:0]  r_res;
    logic [1:0]          r_status;
    t_div_req            r_dreq;
    t_div_rsp            w_drsp;

    logic                w_acc;
    logic                w_wx, w_wy, w_wz;
    logic [XIdxW-1:0]    w_rx;
    logic [YIdxW-1:0]    w_ry;
    logic [GridAw-1:0]   w_rz;
    logic signed [31:0]  w_x, w_y, w_z;
    logic [4:0]          w_nxc, w_nyc;
    logic [3:0]          w_pxc, w_pyc;
    logic [3:0]          w_n;
    logic signed [31:0]  w_q;
    logic signed [32:0]  w_diff;
    logic [5:0]          w_start;
    logic [4:0]          w_cnt;
    logic [3:0]          w_pts;
    logic signed [6:0]   w_st;
    logic signed [65:0]  w_sum;

    assign w_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ovalid;
    assign o_out.result_value = r_res;
    assign o_out.status = r_status;

    assign w_wx = w_acc && (i_in.opcode == OP_LOAD_X);
    assign w_wy = w_acc && (i_in.opcode == OP_LOAD_Y);
    assign w_wz = w_acc && (i_in.opcode == OP_LOAD_Z);

    // clamp registers into legal ranges
    always_comb begin
        w_nxc = (r_nx_used == 5'd0) ? 5'd1 : (r_nx_used > 5'(MaxNodesX) ? 5'(MaxNodesX)
                                                                         : r_nx_used);
        w_nyc = (r_ny_used == 5'd0) ? 5'd1 : (r_ny_used > 5'(MaxNodesY) ? 5'(MaxNodesY)
                                                                         : r_ny_used);
        w_pxc = (r_px_cfg == 4'd0) ? 4'd1 : (r_px_cfg > 4'(MaxPoints) ? 4'(MaxPoints) : r_px_cfg);
        w_pyc = (r_py_cfg == 4'd0) ? 4'd1 : (r_py_cfg > 4'(MaxPoints) ? 4'(MaxPoints) : r_py_cfg);
        if ({1'b0, w_pxc} > w_nxc) w_pxc = w_nxc[3:0];
        if ({1'b0, w_pyc} > w_nyc) w_pyc = w_nyc[3:0];
    end

    // window start from search index
    always_comb begin
        w_cnt = (r_state == S_SRCH_X) ? r_nx : r_ny;
        w_pts = (r_state == S_SRCH_X) ? r_px : r_py;
        w_st = 7'($signed({2'b0, r_idx})) - 7'($signed({3'b0, w_pts >> 1}))
               - 7'($signed({6'b0, w_pts[0]}));
        if (w_st < 0) w_st = '0;
        if (6'(w_st) + 6'(w_pts) > 6'(w_cnt)) w_st = 7'(w_cnt) - 7'(w_pts);
        if ({1'b0, w_pts} >= w_cnt) w_st = '0;
        w_start = w_st[5:0];
    end

    always_comb begin
        w_n = r_xpass ? r_px : r_py;
        w_q = r_xpass ? r_qx : r_qy;
        w_rx = XIdxW'(r_idx);
        w_ry = YIdxW'(r_idx);
        w_rz = {XIdxW'(r_sx + XIdxW'(r_row)), YIdxW'(r_sy + YIdxW'(r_ld))};
        if (r_state == S_ROW_LD) begin
            w_rx = XIdxW'(r_sx + XIdxW'(r_ld));
            w_ry = YIdxW'(r_sy + YIdxW'(r_ld));
        end
        w_diff = 33'(w_q) - 33'(r_win[r_lvl[PtIdxW-1:0] - 1'b1]);
        w_sum = 66'(r_prod / 64'sd65536) + 66'(r_coef[r_lvl[PtIdxW-1:0] - 1'b1]);
    end

    gni_store u_store (
        .i_clk  (i_clk),
        .i_wx   (w_wx),
        .i_wy   (w_wy),
        .i_wz   (w_wz),
        .i_wrow (i_in.row_index),
        .i_wcol (i_in.col_index),
        .i_wdata(i_in.load_value),
        .i_rx   (w_rx),
        .i_ry   (w_ry),
        .i_rz   (w_rz),
        .o_x    (w_x),
        .o_y    (w_y),
        .o_z    (w_z)
    );

    gni_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_dreq),
        .o_rsp  (w_drsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_nx_used <= 5'd16;
            r_ny_used <= 5'd16;
            r_px_cfg  <= 4'd4;
            r_py_cfg  <= 4'd4;
            r_ovalid  <= 1'b0;
            r_dreq.req <= 1'b0;
            r_rdv     <= 1'b0;
        end else begin
            r_dreq.req <= 1'b0;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_X_USED: r_nx_used <= i_cfg.data[4:0];
                    REG_Y_USED: r_ny_used <= i_cfg.data[4:0];
                    REG_PTS_X:  r_px_cfg  <= i_cfg.data[3:0];
                    REG_PTS_Y:  r_py_cfg  <= i_cfg.data[3:0];
                    default: ;
                endcase
            end
            if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            // previous search read lands this cycle
            r_rdv <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && i_in.opcode == OP_QUERY) begin
                        r_qx <= i_in.query_x;
                        r_qy <= i_in.query_y;
                        r_nx <= w_nxc;
                        r_ny <= w_nyc;
                        r_px <= w_pxc;
                        r_py <= w_pyc;
                        r_sat <= 1'b0;
                        r_zero <= 1'b0;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SRCH_X;
                    end
                end
                S_SRCH_X, S_SRCH_Y: begin
                    // one node read at a time, compared when it lands; stop at first node not below q
                    if (r_rdv) begin
                        if (((r_state == S_SRCH_X) ? w_x : w_y) >=
                            ((r_state == S_SRCH_X) ? r_qx : r_qy)) begin
                            r_found <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 5'd1;
                        end
                    end else if (r_found || r_idx >= w_cnt) begin
                        if (r_state == S_SRCH_X) begin
                            r_sx <= XIdxW'(w_start);
                            r_idx <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SRCH_Y;
                        end else begin
                            r_sy <= YIdxW'(w_start);
                            r_xpass <= 1'b0;
                            r_row <= '0;
                            r_ld <= '0;
                            r_state <= S_ROW_LD;
                        end
                    end else begin
                        r_rdv <= 1'b1;
                    end
                end
                S_ROW_LD: begin
                    // wait for read of window node and grid value
                    r_rdj <= r_ld;
                    r_state <= S_ROW_LD2;
                end
                S_ROW_LD2: begin
                    if (r_xpass) begin
                        r_win[r_rdj[PtIdxW-1:0]] <= w_x;
                        r_dw[r_rdj[PtIdxW-1:0]] <= r_rowres[r_rdj[PtIdxW-1:0]];
                    end else begin
                        r_win[r_rdj[PtIdxW-1:0]] <= w_y;
                        r_dw[r_rdj[PtIdxW-1:0]] <= w_z;
                    end
                    if (r_ld + 1'b1 == (PtIdxW+1)'(w_n)) begin
                        r_lvl <= '0;
                        r_j <= '0;
                        r_state <= S_DIV_SET;
                    end else begin
                        r_ld <= r_ld + 1'b1;
                        r_state <= S_ROW_LD;
                    end
                end
                S_DIV_SET: begin
                    if (r_j == '0) r_coef[r_lvl[PtIdxW-1:0]] <= r_dw[0];
                    if (r_lvl + 1'b1 >= (PtIdxW+1)'(w_n)) begin
                        // Horner starts from the top coefficient with lvl at n-1
                        r_p <= r_dw[0];
                        r_state <= S_HORNER;
                    end else begin
                        r_dreq.req <= 1'b1;
                        r_dreq.num <= (64'(r_dw[r_j[PtIdxW-1:0]])
                                      - 64'(r_dw[r_j[PtIdxW-1:0] + 1'b1])) <<< 16;
                        r_dreq.den <= 64'(r_win[r_j[PtIdxW-1:0]])
                                    - 64'(r_win[r_j[PtIdxW-1:0] + r_lvl[PtIdxW-1:0] + 1'b1]);
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (w_drsp.done) begin
                        if (r_dreq.den == 64'sd0) begin
                            r_zero <= 1'b1;
                            r_dw[r_j[PtIdxW-1:0]] <= '0;
                        end else begin
                            r_dw[r_j[PtIdxW-1:0]] <= sat32(66'(w_drsp.quo));
                            if (is_sat(66'(w_drsp.quo))) r_sat <= 1'b1;
                        end
                        if (r_j + r_lvl + 2'd2 >= (PtIdxW+1)'(w_n)) begin
                            r_j <= '0;
                            r_lvl <= r_lvl + 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                        r_state <= S_DIV_SET;
                    end
                end
                S_HORNER: begin
                    // r_lvl counts down from n-1
                    if (r_lvl == '0) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_d <= sat32(66'(w_diff));
                        if (is_sat(66'(w_diff))) r_sat <= 1'b1;
                        r_state <= S_HORN_MUL;
                    end
                end
                S_HORN_MUL: begin
                    if (r_rdv == 1'b0 && r_j == '0) begin
                        r_prod <= 64'(r_d) * 64'(r_p);
                        r_j <= (PtIdxW+1)'(1);
                    end else begin
                        r_p <= sat32(w_sum);
                        if (is_sat(w_sum)) r_sat <= 1'b1;
                        r_j <= '0;
                        r_lvl <= r_lvl - 1'b1;
                        r_state <= S_HORNER;
                    end
                end
                S_NEXT: begin
                    r_ld <= '0;
                    if (r_xpass) begin
                        r_state <= S_DONE;
                    end else begin
                        r_rowres[r_row[PtIdxW-1:0]] <= r_p;
                        if (r_row + 1'b1 == (PtIdxW+1)'(r_px)) begin
                            r_xpass <= 1'b1;
                        end
                        r_row <= r_row + 1'b1;
                        r_state <= S_ROW_LD;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_res <= r_zero ? 32'sd0 : r_p;
                        r_status <= r_zero ? StZero : (r_sat ? StSat : StOk);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("item accepted while busy");
    a_div_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dreq.req |=> (r_state == S_DIV_WAIT))
        else $error("divider issued outside a wait");
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_status == StZero) |-> (r_res == 32'sd0))
        else $error("zero divisor result not cleared");
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |=> (r_ovalid && $stable(r_res) && $stable(r_status)))
        else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

// ===== dv/tb_gni_if.sv =====
// Interface instances are taken from the RTL interface file; this file holds the test item type.
`timescale 1ns / 100ps
package tb_gni_item_pkg;
    import gni_pkg::*;

    typedef struct {
        t_opcode            op;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] lv;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
    } t_grid_item;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_interp_result;
endpackage

// ===== dv/tb_grid_newton_interpolator_2d_unit.sv =====
// Self-checking testbench for the grid Newton interpolator: loads, queries and register settings.
`timescale 1ns / 100ps
module tb_grid_newton_interpolator_2d_unit;
    import gni_pkg::*;
    import tb_gni_item_pkg::*;

    localparam int WatchdogLimit = 100000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gni_in_if  in_ch ();
    gni_cfg_if cfg_ch ();
    gni_out_if out_ch ();

    grid_newton_interpolator_2d_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [4:0]         x_used_reg, y_used_reg;
    logic [3:0]         pts_x_reg, pts_y_reg;
    logic signed [31:0] x_node_tab [MaxNodesX];
    logic signed [31:0] y_node_tab [MaxNodesY];
    logic signed [31:0] z_tab [MaxNodesX][MaxNodesY];
    logic signed [31:0] diff_buf [MaxPoints];
    bit                 sat_flag, zero_flag;

    t_interp_result expected_results[$];
    int  mismatch_count = 0;
    int  result_count = 0;
    int  query_count = 0;
    int  idle_cycles = 0;
    int  out_wait = 0;
    bit  timed_out = 1'b0;
    bit  out_hold = 1'b0;

    function automatic logic signed [31:0] clip32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            sat_flag = 1'b1;
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            sat_flag = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic int clamp_int(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int pick_start(input bit is_x, input int size, input int p,
                                      input logic signed [31:0] q);
        int idx;
        idx = 0;
        if (p >= size) return 0;
        while (idx < size && (is_x ? x_node_tab[idx] : y_node_tab[idx]) < q) idx++;
        idx -= p / 2 + p % 2;
        if (idx < 0) idx = 0;
        if (idx + p > size) idx = size - p;
        return idx;
    endfunction

    // Newton form over n window nodes; consumes diff_buf
    function automatic logic signed [31:0] newton_eval(input logic signed [31:0] nd [MaxPoints],
                                                       input int n,
                                                       input logic signed [31:0] q);
        logic signed [31:0] coef [MaxPoints];
        logic signed [65:0] num, den, prod;
        logic signed [31:0] acc, d;
        coef[0] = diff_buf[0];
        for (int i = 0; i + 1 < n; i++) begin
            for (int j = 0; j + 1 + i < n; j++) begin
                den = 66'(nd[j]) - 66'(nd[j + 1 + i]);
                if (den == 0) begin
                    zero_flag = 1'b1;
                    diff_buf[j] = 0;
                end else begin
                    num = (66'(diff_buf[j]) - 66'(diff_buf[j + 1])) * 66'sd65536;
                    diff_buf[j] = clip32(num / den);
                end
            end
            coef[i + 1] = diff_buf[0];
        end
        acc = coef[n - 1];
        for (int i = n - 1; i > 0; i--) begin
            d = clip32(66'(q) - 66'(nd[i - 1]));
            prod = (66'(d) * 66'(acc)) / 66'sd65536;
            acc = clip32(prod + 66'(coef[i - 1]));
        end
        return acc;
    endfunction

    function automatic void apply_item(input t_grid_item it);
        int nx, ny, px, py, sx, sy;
        logic signed [31:0] wx [MaxPoints];
        logic signed [31:0] wy [MaxPoints];
        logic signed [31:0] rows [MaxPoints];
        t_interp_result r;
        case (it.op)
            OP_LOAD_X: x_node_tab[it.row] = it.lv;
            OP_LOAD_Y: y_node_tab[it.col] = it.lv;
            OP_LOAD_Z: z_tab[it.row][it.col] = it.lv;
            default: begin
                sat_flag = 1'b0;
                zero_flag = 1'b0;
                nx = clamp_int(x_used_reg, 1, MaxNodesX);
                ny = clamp_int(y_used_reg, 1, MaxNodesY);
                px = clamp_int(clamp_int(pts_x_reg, 1, MaxPoints), 1, nx);
                py = clamp_int(clamp_int(pts_y_reg, 1, MaxPoints), 1, ny);
                sx = pick_start(1'b1, nx, px, it.qx);
                sy = pick_start(1'b0, ny, py, it.qy);
                for (int i = 0; i < MaxPoints; i++) begin
                    wx[i] = (i < px) ? x_node_tab[sx + i] : 0;
                    wy[i] = (i < py) ? y_node_tab[sy + i] : 0;
                end
                for (int i = 0; i < px; i++) begin
                    for (int j = 0; j < py; j++) diff_buf[j] = z_tab[sx + i][sy + j];
                    rows[i] = newton_eval(wy, py, it.qy);
                end
                for (int i = 0; i < px; i++) diff_buf[i] = rows[i];
                r.value = newton_eval(wx, px, it.qx);
                if (zero_flag) begin
                    r.status = StZero;
                    r.value = 0;
                end else begin
                    r.status = sat_flag ? StSat : StOk;
                end
                expected_results.push_back(r);
            end
        endcase
    endfunction

    initial begin
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_LOAD_X;
        in_ch.row_index = '0;
        in_ch.col_index = '0;
        in_ch.load_value = '0;
        in_ch.query_x = '0;
        in_ch.query_y = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_X_USED;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // result side: per-result stall drawn at random, compare against oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result value=%0d status=%0d",
                                 out_ch.result_value, out_ch.status);
                end else begin
                    t_interp_result e;
                    e = expected_results.pop_front();
                    if (e.value !== out_ch.result_value || e.status !== out_ch.status) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected value=%0d status=%0d, got %0d/%0d",
                                     e.value, e.status, out_ch.result_value, out_ch.status);
                    end
                end
                out_wait = out_hold ? 0 : $urandom_range(0, 16);
            end else if (out_ch.valid && out_wait > 0) begin
                out_wait--;
            end
            out_ch.ready <= out_hold || (out_wait == 0);
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired");
            $display("FAILURE");
            $finish;
        end
    end

    // valid stays high after a transaction; drop it only for a gap or in drain
    task automatic send_item(input t_grid_item it, input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= it.op;
        in_ch.row_index <= it.row;
        in_ch.col_index <= it.col;
        in_ch.load_value <= it.lv;
        in_ch.query_x <= it.qx;
        in_ch.query_y <= it.qy;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        apply_item(it);
        if (it.op == OP_QUERY) query_count++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_X_USED: x_used_reg = val[4:0];
            REG_Y_USED: y_used_reg = val[4:0];
            REG_PTS_X:  pts_x_reg = val[3:0];
            default:    pts_y_reg = val[3:0];
        endcase
    endtask

    task automatic set_shape(input int nx, input int ny, input int px, input int py);
        drain();
        write_reg(REG_X_USED, 32'(nx));
        write_reg(REG_Y_USED, 32'(ny));
        write_reg(REG_PTS_X, 32'(px));
        write_reg(REG_PTS_Y, 32'(py));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_grid_item mk(input t_opcode op, input int row, input int col,
                                      input logic signed [31:0] lv,
                                      input logic signed [31:0] qx,
                                      input logic signed [31:0] qy);
        t_grid_item it;
        it.op = op; it.row = 4'(row); it.col = 4'(col); it.lv = lv; it.qx = qx; it.qy = qy;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
            default: return $urandom;
        endcase
    endfunction

    // write every node and grid entry (about a quarter of the grid, at random, when wild); nodes ascend unless wild
    task automatic load_table(input bit wild, input int step);
        logic signed [31:0] base;
        base = -(step * 8);
        for (int i = 0; i < MaxNodesX; i++)
            send_item(mk(OP_LOAD_X, i, $urandom_range(0, 15),
                         wild ? rand_word() : base + i * step, $urandom, $urandom),
                      $urandom_range(0, 3) != 0);
        for (int j = 0; j < MaxNodesY; j++)
            send_item(mk(OP_LOAD_Y, $urandom_range(0, 15), j,
                         wild ? rand_word() : base + j * step, $urandom, $urandom),
                      $urandom_range(0, 3) != 0);
        for (int i = 0; i < MaxNodesX; i++)
            for (int j = 0; j < MaxNodesY; j++)
                if (!wild || $urandom_range(0, 3) == 0)
                    send_item(mk(OP_LOAD_Z, i, j,
                                 wild ? rand_word() : $signed($urandom_range(0, 32'h3ffff))
                                                      - 32'sh20000, $urandom, $urandom),
                              $urandom_range(0, 7) != 0);
    endtask

    task automatic test_directed();
        load_table(1'b0, 32'h10000);
        send_item(mk(OP_QUERY, 0, 0, 0, 32'sh00008000, 32'sh00018000));
        send_item(mk(OP_QUERY, 15, 15, 32'sh7fffffff, 32'sh80000000, 32'sh80000000));
        send_item(mk(OP_QUERY, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff));
        send_item(mk(OP_QUERY, 0, 0, 0, 32'sh00070000, 32'shfff90000));
        // repeated node: zero divisor
        send_item(mk(OP_LOAD_X, 9, 0, 32'sh00000000, 0, 0));
        send_item(mk(OP_QUERY, 0, 0, 0, 0, 0));
        send_item(mk(OP_LOAD_X, 9, 0, 32'sh00010000, 0, 0));
        // big value drives saturation
        send_item(mk(OP_LOAD_Z, 8, 8, 32'sh7fffffff, 0, 0));
        send_item(mk(OP_QUERY, 0, 0, 0, 32'sh00004000, 32'sh0000c000));
        // single point, and max points
        set_shape(16, 16, 1, 1);
        send_item(mk(OP_QUERY, 0, 0, 0, 32'sh00020000, 32'shfffe0000));
        set_shape(16, 16, 8, 8);
        send_item(mk(OP_QUERY, 0, 0, 0, 32'sh00001234, 32'shffff4321));
        // out of range registers clamp
        set_shape(0, 31, 15, 0);
        send_item(mk(OP_QUERY, 0, 0, 0, 32'sh00030000, 32'sh00010000));
        set_shape(3, 2, 8, 8);
        send_item(mk(OP_QUERY, 0, 0, 0, 32'sh00100000, 32'shfff00000));
    endtask

    task automatic test_random_queries(input int n_queries, input int n_noise);
        int q, s;
        q = 0; s = 0;
        while (q < n_queries || s < n_noise) begin
            if (q < n_queries && (s >= n_noise || $urandom_range(0, 4) != 0)) begin
                send_item(mk(OP_QUERY, $urandom, $urandom, $urandom,
                             ($urandom_range(0, 7) == 0) ? rand_word()
                                 : $signed($urandom_range(0, 32'h140000)) - 32'sh000a0000,
                             ($urandom_range(0, 7) == 0) ? rand_word()
                                 : $signed($urandom_range(0, 32'h140000)) - 32'sh000a0000));
                q++;
            end else begin
                send_item(mk(t_opcode'($urandom_range(0, 2)), $urandom, $urandom,
                             rand_word(), $urandom, $urandom));
                s++;
            end
        end
    endtask

    task automatic test_settings_sweep();
        for (int k = 0; k < 8; k++) begin
            set_shape($urandom_range(1, 16), $urandom_range(1, 16),
                      ($urandom_range(0, 4) == 0) ? 8 : $urandom_range(1, 4),
                      ($urandom_range(0, 4) == 0) ? 8 : $urandom_range(1, 4));
            test_random_queries(20, 5);
        end
        // hold off until all results are home, with the sink always ready
        out_hold = 1'b1;
        drain();
        test_random_queries(10, 0);
        out_hold = 1'b0;
    endtask

    task automatic test_wild_table();
        drain();
        load_table(1'b1, 0);
        set_shape(16, 16, 4, 4);
        test_random_queries(20, 10);
        set_shape(16, 16, 2, 3);
        test_random_queries(20, 10);
    endtask

    initial begin
        x_used_reg = 16; y_used_reg = 16; pts_x_reg = 4; pts_y_reg = 4;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_settings_sweep();
        test_wild_table();
        drain();
        repeat (100) @(posedge i_clk);
        $display("Covered %0d queries (%0d results) over clamped, single-point, eight-point",
                 query_count, result_count);
        $display("and random shapes, with repeated nodes, saturation and random stalls.");
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
